>>> sv/tle_pkg.sv
// ----------------------------------------------------------------------------
// tle_pkg
// Shared types and constants of the terminal line editor: byte codes,
// action codes, escape phases and the structs passed between modules.
// ----------------------------------------------------------------------------
package tle_pkg;

   // field widths
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 9;

   // longest line the editor keeps
   localparam int LINE_MAX = 256;

   // received byte codes
   localparam logic [BYTE_W-1:0] CH_LF      = 8'd10;
   localparam logic [BYTE_W-1:0] CH_CR      = 8'd13;
   localparam logic [BYTE_W-1:0] CH_ESC     = 8'd27;
   localparam logic [BYTE_W-1:0] CH_BRACKET = 8'd91;
   localparam logic [BYTE_W-1:0] CH_DEL     = 8'd127;
   localparam logic [BYTE_W-1:0] CH_UP      = 8'd65;
   localparam logic [BYTE_W-1:0] CH_DOWN    = 8'd66;
   localparam logic [BYTE_W-1:0] PARAM_LO   = 8'd1;
   localparam logic [BYTE_W-1:0] PARAM_HI   = 8'd6;

   // reported action
   typedef enum logic [2:0] {
      ACT_NONE  = 3'd0,
      ACT_ECHO  = 3'd1,
      ACT_ERASE = 3'd2,
      ACT_END   = 3'd3,
      ACT_FULL  = 3'd4,
      ACT_UP    = 3'd5,
      ACT_DOWN  = 3'd6
   } action_type;

   // escape sequence phase
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_ESC   = 2'd1,
      PH_CSI   = 2'd2,
      PH_PARAM = 2'd3
   } phase_type;

   // editor state carried from beat to beat
   typedef struct packed {
      phase_type         phase;
      logic [LEN_W-1:0]  line_length;
   } state_type;

   // one result beat
   typedef struct packed {
      action_type        action;
      logic [BYTE_W-1:0] echo_byte;
      logic [LEN_W-1:0]  length;
   } result_type;

endpackage

>>> sv/tle_if.sv
// ----------------------------------------------------------------------------
// tle_if
// Valid/ready channels of the terminal line editor: received bytes,
// results and the line limit register write.
// ----------------------------------------------------------------------------
interface tle_req_if;
   logic                      valid;
   logic                      ready;
   logic [tle_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tle_rsp_if;
   logic                       valid;
   logic                       ready;
   tle_pkg::action_type        action;
   logic [tle_pkg::BYTE_W-1:0] echo_byte;
   logic [tle_pkg::LEN_W-1:0]  length;

   modport source (output valid, output action, output echo_byte, output length,
                   input ready);
   modport sink   (input valid, input action, input echo_byte, input length,
                   output ready);
endinterface

interface tle_csr_if;
   logic                      valid;
   logic                      ready;
   logic [tle_pkg::LEN_W-1:0] line_limit;

   modport source (output valid, output line_limit, input ready);
   modport sink   (input valid, input line_limit, output ready);
endinterface

>>> sv/tle_step.sv
// ----------------------------------------------------------------------------
// tle_step
// Line discipline for one received byte: next escape phase and line
// length, and the action reported for the byte.
// ----------------------------------------------------------------------------
module tle_step (
   input  logic [tle_pkg::BYTE_W-1:0] rx_byte,
   input  tle_pkg::state_type         state,
   input  logic [tle_pkg::LEN_W-1:0]  line_limit,
   output tle_pkg::state_type         state_next,
   output tle_pkg::result_type        result
);
   import tle_pkg::*;

   logic [LEN_W-1:0] eff_limit;
   logic [LEN_W-1:0] len_inc;
   logic [LEN_W-1:0] len_dec;
   logic             is_eol;
   logic             is_param;
   logic             is_arrow;
   logic             in_seq;
   logic             line_full;
   logic             not_empty;

   // clamp the limit into 1 .. LINE_MAX
   always_comb begin
      if (line_limit == '0) begin
         eff_limit = LEN_W'(1);
      end else if (line_limit > LEN_W'(LINE_MAX)) begin
         eff_limit = LEN_W'(LINE_MAX);
      end else begin
         eff_limit = line_limit;
      end
   end

   // byte classes and length arithmetic
   assign is_eol    = (rx_byte == CH_CR) || (rx_byte == CH_LF);
   assign is_param  = (rx_byte >= PARAM_LO) && (rx_byte <= PARAM_HI);
   assign is_arrow  = (rx_byte == CH_UP) || (rx_byte == CH_DOWN);
   assign in_seq    = (state.phase == PH_CSI) || (state.phase == PH_PARAM);
   assign len_inc   = state.line_length + LEN_W'(1);
   assign len_dec   = state.line_length - LEN_W'(1);
   assign line_full = (len_inc >= eff_limit);
   assign not_empty = (state.line_length != '0);

   // next state
   always_comb begin
      state_next = state;
      unique case (state.phase) inside
         PH_CSI, PH_PARAM: begin
            if (state.phase == PH_CSI && is_param) begin
               state_next.phase = PH_PARAM;
            end else begin
               state_next.phase = PH_IDLE;
               if (is_arrow) begin
                  state_next.line_length = '0;
               end
            end
         end
         PH_IDLE, PH_ESC: begin
            if (is_eol) begin
               state_next.phase       = PH_IDLE;
               state_next.line_length = '0;
            end else if (rx_byte == CH_BRACKET && state.phase == PH_ESC) begin
               state_next.phase = PH_CSI;
            end else if (rx_byte == CH_ESC) begin
               state_next.phase = PH_ESC;
            end else begin
               state_next.phase = PH_IDLE;
               if (rx_byte == CH_DEL) begin
                  if (not_empty) begin
                     state_next.line_length = len_dec;
                  end
               end else if (line_full) begin
                  state_next.line_length = '0;
               end else begin
                  state_next.line_length = len_inc;
               end
            end
         end
         default: state_next = state;
      endcase
   end

   // reported action
   always_comb begin
      result.action    = ACT_NONE;
      result.echo_byte = '0;
      result.length    = state.line_length;
      if (in_seq) begin
         if (!(state.phase == PH_CSI && is_param)) begin
            if (rx_byte == CH_UP) begin
               result.action = ACT_UP;
            end else if (rx_byte == CH_DOWN) begin
               result.action = ACT_DOWN;
            end
         end
      end else if (is_eol) begin
         result.action = ACT_END;
      end else if ((rx_byte == CH_BRACKET && state.phase == PH_ESC) ||
                   rx_byte == CH_ESC) begin
         result.action = ACT_NONE;
      end else if (rx_byte == CH_DEL) begin
         if (not_empty) begin
            result.action = ACT_ERASE;
            result.length = len_dec;
         end
      end else if (line_full) begin
         result.action    = ACT_FULL;
         result.echo_byte = rx_byte;
         result.length    = len_inc;
      end else begin
         result.action    = ACT_ECHO;
         result.echo_byte = rx_byte;
      end
   end

endmodule

>>> sv/terminal_line_editor.sv
// ----------------------------------------------------------------------------
// terminal_line_editor
// Serial line discipline with arrow keys: one received byte in, one
// action out, with a running line length and an escape sub-state.
// ----------------------------------------------------------------------------
//  channel   dir  payload                      beat when
//  req_if    in   rx_byte[7:0]                 valid && ready
//  rsp_if    out  action, echo_byte, length    valid && ready
//  csr_if    in   line_limit[8:0]              valid && ready (always ready)
//
//  each byte passes from request beat to result through the input
//  register, then the result register; one byte per cycle while the result is not stalled
//  line length and escape phase update as a byte moves into the result register
//  reset clears both registers' valid bits, the state and sets the limit to 256
//  a stalled result holds its register; the input register still takes one byte
// ----------------------------------------------------------------------------
module terminal_line_editor (
   input  logic       clock,
   input  logic       reset,
   tle_req_if.sink    req_if,
   tle_rsp_if.source  rsp_if,
   tle_csr_if.sink    csr_if
);
   import tle_pkg::*;

   logic [LEN_W-1:0]  line_limit_ff;
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   result_type        rsp_ff;
   state_type         state_ff;
   state_type         state_next;
   result_type        step_result;
   logic              out_free;
   logic              advance;
   logic              req_beat;

   // handshake control
   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign advance       = in_valid_ff && out_free;
   assign req_if.ready  = !in_valid_ff || out_free;
   assign req_beat      = req_if.valid && req_if.ready;
   assign in_valid_in   = req_beat ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in  = advance ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);
   assign csr_if.ready  = 1'b1;

   // line limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         line_limit_ff <= LEN_W'(LINE_MAX);
      end else if (csr_if.valid && csr_if.ready) begin
         line_limit_ff <= csr_if.line_limit;
      end
   end

   // valid bits and editor state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{phase: PH_IDLE, line_length: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_next;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_byte_ff <= req_if.rx_byte;
      end
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   // per-byte discipline
   tle_step u_step (
      .rx_byte    (in_byte_ff),
      .state      (state_ff),
      .line_limit (line_limit_ff),
      .state_next (state_next),
      .result     (step_result)
   );

   // result channel
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.action    = rsp_ff.action;
   assign rsp_if.echo_byte = rsp_ff.echo_byte;
   assign rsp_if.length    = rsp_ff.length;

endmodule

>>> sv/tle_check.sv
// ----------------------------------------------------------------------------
// tle_check
// Port-level checks of the terminal line editor, bound to the top level.
// ----------------------------------------------------------------------------
module tle_check (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input tle_pkg::action_type        rsp_action,
   input logic [tle_pkg::BYTE_W-1:0] rsp_echo_byte,
   input logic [tle_pkg::LEN_W-1:0]  rsp_length
);
   import tle_pkg::*;

   // a result waits until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before its beat");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // only stored bytes carry an echo byte
   a_echo_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != ACT_ECHO && rsp_action != ACT_FULL
         |-> rsp_echo_byte == '0)
      else $error("echo byte set on a non-storing action");

   // a full line holds at least one character
   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_FULL |-> rsp_length != '0)
      else $error("line full with zero length");

   // a stored byte sits below the longest line
   a_echo_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_ECHO |-> rsp_length < LEN_W'(LINE_MAX))
      else $error("echo position beyond longest line");

endmodule

bind terminal_line_editor tle_check u_tle_check (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_action    (rsp_if.action),
   .rsp_echo_byte (rsp_if.echo_byte),
   .rsp_length    (rsp_if.length)
);
